// ===== rtl/core/wasm_section_deframer_assert.svh =====
// assertion macros for the wasm section deframer
`ifndef WASM_SECTION_DEFRAMER_ASSERT_SVH
`define WASM_SECTION_DEFRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// property checked on every clock edge outside reset
`define WSD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("wsd assertion failed");
// property checked on every clock edge, reset included
`define WSD_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("wsd assertion failed");
`else
`define WSD_ASSERT(lbl, prop)
`define WSD_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/core/wsd_pkg.sv =====
// types and constants shared by the wasm section deframer
`timescale 1ns / 1ps
package wsd_pkg;

	// result kinds
	localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
	localparam logic [2:0] KIND_EMPTY     = 3'd1;
	localparam logic [2:0] KIND_BAD_MAGIC = 3'd2;
	localparam logic [2:0] KIND_BAD_ID    = 3'd3;
	localparam logic [2:0] KIND_TRUNC     = 3'd4;
	localparam logic [2:0] KIND_OVERLONG  = 3'd5;

	// last header byte index and last size byte index
	localparam logic [2:0] HDR_LAST      = 3'd3;
	localparam logic [2:0] SIZE_LAST_IDX = 3'd4;

	typedef enum logic [2:0] {
		PH_MAGIC   = 3'd0,
		PH_VERSION = 3'd1,
		PH_ID      = 3'd2,
		PH_SIZE    = 3'd3,
		PH_PAYLOAD = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       final_byte;
	} in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  section_id;
		logic [7:0]  payload_byte;
		logic [31:0] byte_offset;
		logic        section_last;
	} out_t;

	// framer status toward the top level
	typedef struct packed {
		logic halted;
		logic valid;
		out_t item;
	} step_t;

	// expected magic byte at header position
	function automatic logic [7:0] magic_byte(input logic [1:0] pos);
		logic [7:0] m;
		case (pos)
			2'd0: m = 8'h00;
			2'd1: m = 8'h61;
			2'd2: m = 8'h73;
			default: m = 8'h6d;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/core/wsd_framer.sv =====
// section framing state machine: one request per step, at most one result
`timescale 1ns / 1ps
module wsd_framer #(
	parameter int NUM_SECTIONS = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step_en,
	input  wsd_pkg::in_t in_item,
	output wsd_pkg::step_t status
);
	import wsd_pkg::*;

	phase_t      phase_q, phase_n;
	logic [2:0]  hc_q, hc_n;
	logic [7:0]  id_q, id_n;
	logic [31:0] size_q, size_n;
	logic [31:0] rem_q, rem_n;
	logic [31:0] pidx_q, pidx_n;
	logic        halted_q, halted_n;

	logic        res_valid;
	out_t        res_item;
	logic        keep_res;
	logic        abort;
	logic [31:0] size_part;
	logic        id_ok;
	logic        b_ok;
	logic [7:0]  b;

	assign b     = in_item.data_byte;
	assign id_ok = {1'b0, id_q} < 9'(NUM_SECTIONS);
	assign b_ok  = {1'b0, b} < 9'(NUM_SECTIONS);

	// size group shifted to its LEB128 position
	always_comb begin
		case (hc_q)
			3'd0: size_part = {25'd0, b[6:0]};
			3'd1: size_part = {18'd0, b[6:0], 7'd0};
			3'd2: size_part = {11'd0, b[6:0], 14'd0};
			3'd3: size_part = {4'd0, b[6:0], 21'd0};
			3'd4: size_part = {b[3:0], 28'd0};
			default: size_part = 32'd0;
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_MAGIC;
			hc_q     <= 3'd0;
			id_q     <= 8'd0;
			size_q   <= 32'd0;
			rem_q    <= 32'd0;
			pidx_q   <= 32'd0;
			halted_q <= 1'b0;
		end else begin
			phase_q  <= phase_n;
			hc_q     <= hc_n;
			id_q     <= id_n;
			size_q   <= size_n;
			rem_q    <= rem_n;
			pidx_q   <= pidx_n;
			halted_q <= halted_n;
		end
	end

	// next state and result for one request
	always_comb begin
		phase_n   = phase_q;
		hc_n      = hc_q;
		id_n      = id_q;
		size_n    = size_q;
		rem_n     = rem_q;
		pidx_n    = pidx_q;
		halted_n  = halted_q;
		res_valid = 1'b0;
		res_item  = '0;
		keep_res  = 1'b0;
		abort     = 1'b0;
		if (step_en && !halted_q) begin
			case (phase_q)
				PH_MAGIC: begin
					if (b != magic_byte(hc_q[1:0])) begin
						res_valid     = 1'b1;
						res_item.kind = KIND_BAD_MAGIC;
						halted_n      = 1'b1;
						abort         = 1'b1;
					end else if (hc_q == HDR_LAST) begin
						hc_n    = 3'd0;
						phase_n = PH_VERSION;
					end else begin
						hc_n = hc_q + 3'd1;
					end
				end
				PH_VERSION: begin
					if (hc_q == HDR_LAST) begin
						hc_n    = 3'd0;
						phase_n = PH_ID;
					end else begin
						hc_n = hc_q + 3'd1;
					end
				end
				PH_ID: begin
					id_n    = b;
					size_n  = 32'd0;
					hc_n    = 3'd0;
					phase_n = PH_SIZE;
					if (!b_ok) begin
						res_valid           = 1'b1;
						res_item.kind       = KIND_BAD_ID;
						res_item.section_id = b;
					end
				end
				PH_SIZE: begin
					if (hc_q >= SIZE_LAST_IDX && b[7:4] != 4'd0) begin
						res_valid           = 1'b1;
						res_item.kind       = KIND_OVERLONG;
						res_item.section_id = id_q;
						keep_res            = 1'b1;
						hc_n                = 3'd0;
						size_n              = 32'd0;
						phase_n             = PH_ID;
					end else begin
						size_n = size_q | size_part;
						hc_n   = hc_q + 3'd1;
						if (!b[7]) begin
							hc_n = 3'd0;
							if (size_n == 32'd0) begin
								phase_n = PH_ID;
								if (id_ok) begin
									res_valid           = 1'b1;
									res_item.kind       = KIND_EMPTY;
									res_item.section_id = id_q;
								end
							end else begin
								rem_n   = size_n;
								pidx_n  = 32'd0;
								phase_n = PH_PAYLOAD;
							end
						end
					end
				end
				PH_PAYLOAD: begin
					if (id_ok) begin
						res_valid             = 1'b1;
						res_item.kind         = KIND_PAYLOAD;
						res_item.section_id   = id_q;
						res_item.payload_byte = b;
						res_item.byte_offset  = pidx_q;
						res_item.section_last = (rem_q == 32'd1);
					end
					pidx_n = pidx_q + 32'd1;
					rem_n  = rem_q - 32'd1;
					if (rem_q == 32'd1) begin
						phase_n = PH_ID;
					end
				end
				default: begin
					phase_n = PH_MAGIC;
				end
			endcase

			// end of module: report truncation, then restart framing
			if (in_item.final_byte && !abort) begin
				if (phase_n != PH_ID && !keep_res) begin
					res_valid           = 1'b1;
					res_item            = '0;
					res_item.kind       = KIND_TRUNC;
					res_item.section_id =
						(phase_n == PH_MAGIC || phase_n == PH_VERSION) ? 8'd0 : id_n;
				end
				phase_n = PH_MAGIC;
				hc_n    = 3'd0;
				id_n    = 8'd0;
				size_n  = 32'd0;
				rem_n   = 32'd0;
				pidx_n  = 32'd0;
			end
		end
	end

	assign status.halted = halted_q;
	assign status.valid  = res_valid;
	assign status.item   = res_item;

endmodule

// ===== rtl/core/wasm_section_deframer.sv =====
// top level of the wasm section deframer: input register, framer, result register
`timescale 1ns / 1ps
`include "wasm_section_deframer_assert.svh"
// Takes a WebAssembly module one byte per request and returns its section payload
// bytes tagged with section id, offset and a last-of-section mark, plus empty-section
// and error results. One byte is accepted every cycle while results are taken; a byte
// is held in the input register, its result in the result register. The framing state
// is updated between those two registers, which is what sets the
// one-byte-per-cycle figure. A stalled result stalls byte
// intake through a combinational path from result_ready to byte_ready. After a
// bad magic result the block drops all bytes until reset.
module wasm_section_deframer #(
	parameter int NUM_SECTIONS = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          byte_valid,
	output logic          byte_ready,
	input  wsd_pkg::in_t  byte_data,
	output logic          result_valid,
	input  logic          result_ready,
	output wsd_pkg::out_t result_data
);
	import wsd_pkg::*;

	logic  valid_s1;
	in_t   data_s1;
	logic  advance;
	logic  out_free;
	step_t status;
	logic  out_valid_q;
	out_t  out_data_q;

	assign out_free   = !out_valid_q || result_ready;
	assign advance    = valid_s1 && out_free;
	assign byte_ready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			data_s1 <= byte_data;
		end
	end

	wsd_framer #(
		.NUM_SECTIONS(NUM_SECTIONS)
	) u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(advance),
		.in_item(data_s1),
		.status (status)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= status.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && status.valid) begin
			out_data_q <= status.item;
		end
	end

	assign result_valid = out_valid_q;
	assign result_data  = out_data_q;

	// a free result slot always lets a byte in
	`WSD_ASSERT(a_ready_when_free, out_free |-> byte_ready)
	// the framer only produces a result for a byte that is moving on
	`WSD_ASSERT(a_result_on_step, status.valid |-> advance)
	// bad magic halts the block from the next cycle
	`WSD_ASSERT(a_halt_on_magic, (status.valid && status.item.kind == KIND_BAD_MAGIC) |=> status.halted)
	// halted holds until reset
	`WSD_ASSERT(a_halt_sticky, status.halted |=> status.halted)
	// the halted framer produces no result
	`WSD_ASSERT_ALWAYS(a_halt_silent, status.halted |-> !status.valid)

endmodule

// ===== sim/tb_wasm_section_deframer.sv =====
// testbench for the wasm section deframer: directed table, random modules, scoreboard
`timescale 1ns / 1ps
module tb_wasm_section_deframer;
	import wsd_pkg::*;

	localparam int NUM_SECTIONS = 12;
	localparam logic [7:0] WASM_MAGIC [4] = '{8'h00, 8'h61, 8'h73, 8'h6d};
	localparam out_t NO_RESULT = '0;

	// one row of the directed table; typed rows carry their own expectation
	typedef struct packed {
		in_t  req;
		logic typed;
		logic has;
		out_t want;
	} dir_row_t;

	localparam dir_row_t DIRECTED_ROWS [25] = '{
		'{'{8'h00, 1'b0}, 1'b1, 1'b0, NO_RESULT},
		'{'{8'h61, 1'b0}, 1'b1, 1'b0, NO_RESULT},
		'{'{8'h73, 1'b0}, 1'b1, 1'b0, NO_RESULT},
		'{'{8'h6d, 1'b0}, 1'b1, 1'b0, NO_RESULT},
		'{'{8'hff, 1'b0}, 1'b1, 1'b0, NO_RESULT},
		'{'{8'hff, 1'b0}, 1'b1, 1'b0, NO_RESULT},
		'{'{8'h00, 1'b0}, 1'b1, 1'b0, NO_RESULT},
		'{'{8'h01, 1'b0}, 1'b1, 1'b0, NO_RESULT},
		'{'{8'h00, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		'{'{8'h02, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		'{'{8'hff, 1'b0}, 1'b1, 1'b1, '{KIND_PAYLOAD, 8'h00, 8'hff, 32'd0, 1'b0}},
		'{'{8'h00, 1'b0}, 1'b1, 1'b1, '{KIND_PAYLOAD, 8'h00, 8'h00, 32'd1, 1'b1}},
		'{'{8'h0b, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		'{'{8'h00, 1'b0}, 1'b1, 1'b1, '{KIND_EMPTY, 8'h0b, 8'h00, 32'd0, 1'b0}},
		'{'{8'hff, 1'b0}, 1'b1, 1'b1, '{KIND_BAD_ID, 8'hff, 8'h00, 32'd0, 1'b0}},
		'{'{8'h80, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		'{'{8'h80, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		'{'{8'h80, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		'{'{8'h80, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		'{'{8'h10, 1'b0}, 1'b1, 1'b1, '{KIND_OVERLONG, 8'hff, 8'h00, 32'd0, 1'b0}},
		'{'{8'h0c, 1'b0}, 1'b1, 1'b1, '{KIND_BAD_ID, 8'h0c, 8'h00, 32'd0, 1'b0}},
		'{'{8'h01, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		'{'{8'h5a, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		'{'{8'h03, 1'b0}, 1'b0, 1'b0, NO_RESULT},
		'{'{8'h85, 1'b1}, 1'b1, 1'b1, '{KIND_TRUNC, 8'h03, 8'h00, 32'd0, 1'b0}}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic byte_valid;
	logic byte_ready;
	in_t  byte_data;
	logic result_valid;
	logic result_ready;
	out_t result_data;

	// expectation travelling with the request in flight
	logic row_typed;
	logic row_has;
	out_t row_want;

	// predictor state
	phase_t      ph;
	logic [2:0]  hdr_cnt;
	logic [7:0]  sec_id;
	logic [31:0] size_acc;
	logic [31:0] bytes_left;
	logic [31:0] pay_off;
	bit          stopped;

	out_t due_results[$];
	int   errs;
	int   bytes_sent;
	bit   steady;

	wasm_section_deframer #(
		.NUM_SECTIONS(NUM_SECTIONS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.byte_data   (byte_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_data (result_data)
	);

	always #2 clk = ~clk;

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// advance the section framing by one byte; returns 1 when a result is due
	function automatic bit frame_byte(input in_t req, output out_t res);
		logic [7:0] b;
		bit has;
		bit keep;
		b = req.data_byte;
		has = 1'b0;
		keep = 1'b0;
		res = '0;
		if (stopped) return 1'b0;
		case (ph)
			PH_MAGIC: begin
				if (b != WASM_MAGIC[hdr_cnt[1:0]]) begin
					res.kind = KIND_BAD_MAGIC;
					stopped = 1'b1;
					return 1'b1;
				end
				if (hdr_cnt == HDR_LAST) begin
					hdr_cnt = '0;
					ph = PH_VERSION;
				end else begin
					hdr_cnt++;
				end
			end
			PH_VERSION: begin
				if (hdr_cnt == HDR_LAST) begin
					hdr_cnt = '0;
					ph = PH_ID;
				end else begin
					hdr_cnt++;
				end
			end
			PH_ID: begin
				sec_id = b;
				size_acc = '0;
				hdr_cnt = '0;
				ph = PH_SIZE;
				if (b >= NUM_SECTIONS) begin
					res.kind = KIND_BAD_ID;
					res.section_id = b;
					has = 1'b1;
				end
			end
			PH_SIZE: begin
				// fifth size byte may only carry bits 3..0
				if (hdr_cnt >= SIZE_LAST_IDX && b[7:4] != 4'd0) begin
					res.kind = KIND_OVERLONG;
					res.section_id = sec_id;
					has = 1'b1;
					keep = 1'b1;
					hdr_cnt = '0;
					size_acc = '0;
					ph = PH_ID;
				end else begin
					size_acc |= 32'(b[6:0]) << (7 * hdr_cnt);
					hdr_cnt++;
					if (!b[7]) begin
						hdr_cnt = '0;
						if (size_acc == 32'd0) begin
							ph = PH_ID;
							if (sec_id < NUM_SECTIONS) begin
								res.kind = KIND_EMPTY;
								res.section_id = sec_id;
								has = 1'b1;
							end
						end else begin
							bytes_left = size_acc;
							pay_off = '0;
							ph = PH_PAYLOAD;
						end
					end
				end
			end
			default: begin
				if (sec_id < NUM_SECTIONS) begin
					res.kind = KIND_PAYLOAD;
					res.section_id = sec_id;
					res.payload_byte = b;
					res.byte_offset = pay_off;
					res.section_last = (bytes_left == 32'd1);
					has = 1'b1;
				end
				pay_off++;
				bytes_left--;
				if (bytes_left == 32'd0) ph = PH_ID;
			end
		endcase
		// end of module: truncation unless at a section boundary
		if (req.final_byte) begin
			if (ph != PH_ID && !keep) begin
				res = '0;
				res.kind = KIND_TRUNC;
				res.section_id = (ph == PH_MAGIC || ph == PH_VERSION) ? 8'h00 : sec_id;
				has = 1'b1;
			end
			ph = PH_MAGIC;
			hdr_cnt = '0;
			sec_id = '0;
			size_acc = '0;
			bytes_left = '0;
			pay_off = '0;
		end
		return has;
	endfunction

	// scoreboard: predict on each accepted request, check each accepted result
	always @(posedge clk) begin
		out_t pred;
		out_t want;
		out_t got;
		bit has;
		if (arst_n) begin
			if (byte_valid && byte_ready) begin
				has = frame_byte(byte_data, pred);
				if (row_typed) begin
					if (row_has) due_results.push_back(row_want);
				end else if (has) begin
					due_results.push_back(pred);
				end
			end
			if (result_valid && result_ready) begin
				got = result_data;
				if (due_results.size() == 0) begin
					$error("unexpected result: kind %0d id %0d", got.kind, got.section_id);
					errs++;
				end else begin
					want = due_results.pop_front();
					if (got.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, got.kind);
						errs++;
					end
					if (got.section_id !== want.section_id) begin
						$error("section_id: expected %0d, got %0d",
							want.section_id, got.section_id);
						errs++;
					end
					if (got.payload_byte !== want.payload_byte) begin
						$error("payload_byte: expected %0d, got %0d",
							want.payload_byte, got.payload_byte);
						errs++;
					end
					if (got.byte_offset !== want.byte_offset) begin
						$error("byte_offset: expected %0d, got %0d",
							want.byte_offset, got.byte_offset);
						errs++;
					end
					if (got.section_last !== want.section_last) begin
						$error("section_last: expected %0d, got %0d",
							want.section_last, got.section_last);
						errs++;
					end
				end
			end
		end
	end

	// result side back-pressure
	initial begin
		int hold;
		forever begin
			result_ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			hold = pick_gap();
			if (hold > 0) begin
				result_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
		end
	end

	// send one request, with an optional idle gap in front
	task automatic put_byte(input in_t req, input logic typed, input logic has,
		input out_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_data <= req;
		row_typed <= typed;
		row_has <= has;
		row_want <= want;
		do @(posedge clk); while (!byte_ready);
		bytes_sent++;
	endtask

	// one random module, mostly well formed, sometimes cut short
	task automatic send_module();
		logic [7:0] mod_bytes[$];
		logic [7:0] sid;
		logic [7:0] leb;
		logic [31:0] rest;
		in_t req;
		int n_sec;
		int sz;
		int pad;
		int cut;
		int pick;
		bit more;
		bit huge;
		huge = 1'b0;
		for (int i = 0; i < 4; i++) mod_bytes.push_back(WASM_MAGIC[i]);
		repeat (4) mod_bytes.push_back(8'($urandom));
		n_sec = $urandom_range(0, 6);
		for (int s = 0; s < n_sec && !huge; s++) begin
			if ($urandom_range(0, 6) == 0)
				sid = 8'($urandom_range(NUM_SECTIONS, 255));
			else
				sid = 8'($urandom_range(0, NUM_SECTIONS - 1));
			mod_bytes.push_back(sid);
			pick = $urandom_range(0, 19);
			if (pick < 2) begin
				// five-byte size with high bits set in the last byte
				repeat (4) mod_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
				mod_bytes.push_back(8'($urandom_range(16, 255)));
			end else if (pick == 2) begin
				// legal but huge size: a few payload bytes, then the module ends
				repeat (4) mod_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
				mod_bytes.push_back(8'($urandom_range(1, 15)));
				repeat ($urandom_range(0, 8)) mod_bytes.push_back(8'($urandom));
				huge = 1'b1;
			end else begin
				pick = $urandom_range(0, 15);
				if (pick < 3) sz = 0;
				else if (pick == 15) sz = $urandom_range(100, 200);
				else sz = $urandom_range(1, 16);
				pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 1;
				// leb128, padded with continuation bytes up to pad bytes
				rest = sz;
				for (int k = 0; k < 5; k++) begin
					leb = {1'b0, rest[6:0]};
					rest = rest >> 7;
					more = (rest != 0) || (k + 1 < pad);
					if (more) leb[7] = 1'b1;
					mod_bytes.push_back(leb);
					if (!more) break;
				end
				repeat (sz) mod_bytes.push_back(8'($urandom));
			end
		end
		cut = mod_bytes.size() - 1;
		if (!huge && $urandom_range(0, 4) == 0) cut = $urandom_range(0, mod_bytes.size() - 1);
		for (int i = 0; i <= cut; i++) begin
			req.data_byte = mod_bytes[i];
			req.final_byte = (i == cut);
			put_byte(req, 1'b0, 1'b0, NO_RESULT);
		end
	endtask

	// stimulus and end of run
	initial begin
		in_t req;
		int pos;
		arst_n <= 1'b0;
		byte_valid <= 1'b0;
		byte_data <= '0;
		row_typed <= 1'b0;
		row_has <= 1'b0;
		row_want <= '0;
		ph = PH_MAGIC;
		hdr_cnt = '0;
		sec_id = '0;
		size_acc = '0;
		bytes_left = '0;
		pay_off = '0;
		stopped = 1'b0;
		errs = 0;
		bytes_sent = 0;
		steady = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (DIRECTED_ROWS[i])
			put_byte(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].has,
				DIRECTED_ROWS[i].want);

		// random modules, some with no idling at all
		while (bytes_sent < 1200) begin
			steady = ($urandom_range(0, 4) == 0);
			send_module();
		end
		steady = 1'b0;

		// bad magic at a random header position, then bytes the block must drop
		pos = $urandom_range(0, 3);
		for (int i = 0; i < pos; i++) begin
			req.data_byte = WASM_MAGIC[i];
			req.final_byte = 1'b0;
			put_byte(req, 1'b0, 1'b0, NO_RESULT);
		end
		req.data_byte = WASM_MAGIC[pos] ^ 8'($urandom_range(1, 255));
		req.final_byte = 1'($urandom);
		put_byte(req, 1'b0, 1'b0, NO_RESULT);
		for (int i = 0; i < 4; i++) begin
			req.data_byte = (i == 0) ? WASM_MAGIC[0] : 8'($urandom);
			req.final_byte = (i == 2);
			put_byte(req, 1'b0, 1'b0, NO_RESULT);
		end
		byte_valid <= 1'b0;

		while (due_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errs == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// hang guard
	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/wsd_pkg.sv
rtl/core/wsd_framer.sv
rtl/core/wasm_section_deframer.sv
sim/tb_wasm_section_deframer.sv
